@@ rtl/core/b64sd_pkg.sv @@
package b64sd_pkg;

    // Position within the current quadruplet.
    typedef enum logic [2:0] {
        PH_FIRST  = 3'd0,
        PH_SECOND = 3'd1,
        PH_THIRD  = 3'd2,
        PH_FOURTH = 3'd3,
        PH_PAD    = 3'd4
    } phase_t;

    localparam logic [7:0] CHAR_PAD = 8'h3D;

    // Sextet lookup: bit 6 set means the character belongs to the alphabet.
    typedef struct packed {
        logic       valid;
        logic [5:0] value;
    } sextet_t;

    function automatic sextet_t sextet_of(input logic [7:0] ch);
        sextet_t s;
        s.valid = 1'b1;
        s.value = 6'd0;
        case (ch) inside
            [8'h41:8'h5A]: s.value = 6'(ch - 8'h41);
            [8'h61:8'h7A]: s.value = 6'(ch - 8'h61 + 8'd26);
            [8'h30:8'h39]: s.value = 6'(ch - 8'h30 + 8'd52);
            8'h2B:         s.value = 6'd62;
            8'h2F:         s.value = 6'd63;
            default:       s.valid = 1'b0;
        endcase
        return s;
    endfunction

    function automatic logic is_skippable(input logic [7:0] ch);
        logic skip;
        case (ch) inside
            8'h20, 8'h09, 8'h0A, 8'h0C, 8'h0D: skip = 1'b1;
            default:                           skip = 1'b0;
        endcase
        return skip;
    endfunction

endpackage

@@ rtl/core/base64_stream_decoder.sv @@
// A word accepted is held in the input register; its decoded byte or error word,
// if it yields one, is then loaded into the result register, where out_valid
// rises with it and the word waits until out_ready takes it.
// Throughput: one character word per cycle; the only stall comes from out_ready.
// Reset (rst_n low, asynchronous): pipeline emptied, quadruplet phase back to the first
// position, error flag cleared. A last_in_message word clears phase and flag too.
module base64_stream_decoder (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] character,
    input  logic       last_in_message,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] data_byte,
    output logic       is_error
);
    import b64sd_pkg::*;

    // Input register stage.
    logic       in_valid_reg;
    logic [7:0] character_reg;
    logic       last_reg;

    // Decoder state. Only the last sextet received matters for the next byte,
    // so six bits of history are enough.
    phase_t     phase_reg,   phase_next;
    logic [5:0] partial_reg, partial_next;
    logic       error_seen_reg, error_seen_next;

    // Result register stage.
    logic       out_valid_reg;
    logic [7:0] data_byte_reg;
    logic       is_error_reg;

    logic       advance;
    logic       stage_fire;
    logic       active;
    logic       is_pad;
    sextet_t    sx;
    logic       emit;
    logic       bad;
    logic [7:0] byte_val;

    // The result register can take a new word when it is empty or being
    // drained this cycle; the input register refills whenever it moves on.
    assign advance    = !out_valid_reg || out_ready;
    assign stage_fire = in_valid_reg && advance;
    assign in_ready   = !in_valid_reg || advance;

    assign sx     = sextet_of(character_reg);
    assign is_pad = (character_reg == CHAR_PAD);
    // Characters after an error, and whitespace, are simply dropped.
    assign active = !error_seen_reg && !is_skippable(character_reg);

    // Output decode: what this character produces.
    always_comb
    begin
        emit     = 1'b0;
        bad      = 1'b0;
        byte_val = 8'd0;
        if (active)
        begin
            case (phase_reg)
                PH_SECOND:
                begin
                    if (sx.valid)
                    begin
                        emit     = 1'b1;
                        byte_val = {partial_reg, sx.value[5:4]};
                    end
                    else
                    begin
                        bad = 1'b1;
                    end
                end
                PH_THIRD:
                begin
                    if (sx.valid)
                    begin
                        emit     = 1'b1;
                        byte_val = {partial_reg[3:0], sx.value[5:2]};
                    end
                    else if (!is_pad)
                    begin
                        bad = 1'b1;
                    end
                end
                PH_FOURTH:
                begin
                    if (sx.valid)
                    begin
                        emit     = 1'b1;
                        byte_val = {partial_reg[1:0], sx.value};
                    end
                    else if (!is_pad)
                    begin
                        bad = 1'b1;
                    end
                end
                PH_PAD:
                begin
                    bad = !is_pad;
                end
                default:
                begin
                    // First position, and any unused phase code treated alike.
                    bad = !sx.valid;
                end
            endcase
        end
    end

    // Next-state decode.
    always_comb
    begin
        phase_next      = phase_reg;
        partial_next    = partial_reg;
        error_seen_next = error_seen_reg || bad;
        if (active && !bad)
        begin
            case (phase_reg)
                PH_SECOND:
                begin
                    phase_next   = PH_THIRD;
                    partial_next = sx.value;
                end
                PH_THIRD:
                begin
                    phase_next   = is_pad ? PH_PAD : PH_FOURTH;
                    partial_next = is_pad ? 6'd0 : sx.value;
                end
                PH_FOURTH, PH_PAD:
                begin
                    phase_next   = PH_FIRST;
                    partial_next = 6'd0;
                end
                default:
                begin
                    phase_next   = PH_SECOND;
                    partial_next = sx.value;
                end
            endcase
        end
        // The end of a message returns everything to its reset value, even
        // partway through a quadruplet.
        if (last_reg)
        begin
            phase_next      = PH_FIRST;
            partial_next    = 6'd0;
            error_seen_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            phase_reg      <= PH_FIRST;
            partial_reg    <= 6'd0;
            error_seen_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                in_valid_reg <= in_valid;
            end
            if (stage_fire)
            begin
                phase_reg      <= phase_next;
                partial_reg    <= partial_next;
                error_seen_reg <= error_seen_next;
            end
            if (advance)
            begin
                out_valid_reg <= stage_fire && (emit || bad);
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            character_reg <= character;
            last_reg      <= last_in_message;
        end
        if (stage_fire)
        begin
            data_byte_reg <= byte_val;
            is_error_reg  <= bad;
        end
    end

    assign out_valid = out_valid_reg;
    assign data_byte = data_byte_reg;
    assign is_error  = is_error_reg;

    // An error word always carries a zero byte.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && is_error |-> data_byte == 8'd0)
        else $error("error word with non-zero data byte");

    // Once an error is flagged, nothing more comes out of this message.
    assert property (@(posedge clk) disable iff (!rst_n)
        error_seen_reg |-> !emit && !bad)
        else $error("result produced after an error in the same message");

    // A bad character that does not end the message sets the error flag.
    assert property (@(posedge clk) disable iff (!rst_n)
        stage_fire && bad && !last_reg |=> error_seen_reg)
        else $error("error flag not set after bad character");

    // The end of a message always returns the phase to the first position and clears the error flag.
    assert property (@(posedge clk) disable iff (!rst_n)
        stage_fire && last_reg |=> phase_reg == PH_FIRST && !error_seen_reg)
        else $error("state not cleared at end of message");

endmodule
